### rtl/f32l_pkg.sv
// Shared types and constants for the FAT32 layout and cluster map block.
package f32l_pkg;

   localparam int unsigned DIV_WIDTH    = 32;
   localparam int unsigned SPC_WIDTH    = 8;
   localparam int unsigned FAT_WIDTH    = 26;
   localparam int unsigned NEED_WIDTH   = 27;
   localparam int unsigned CBYTES_WIDTH = 17;

   localparam logic [31:0] RSVD_SECTORS = 32'd32;
   localparam logic [31:0] EOC_MIN      = 32'h0FFF_FFF8;
   localparam logic [31:0] CLUSTER_MIN  = 32'h0000_0002;
   localparam logic [31:0] CLUSTER_MAX  = 32'h0FFF_FFEF;
   localparam logic [32:0] FAT_ROUND    = 33'd127;

   // One slot of the divider chain: remaining dividend bits shift out of the top
   // of word while quotient bits shift in at the bottom.
   typedef struct packed {
      logic                 valid;
      logic [DIV_WIDTH-1:0] word;
      logic [SPC_WIDTH-1:0] rem;
      logic [SPC_WIDTH-1:0] divisor;
   } div_stage_type;

   typedef struct packed {
      logic [FAT_WIDTH-1:0]    fat_sectors;
      logic [31:0]             cluster_count;
      logic [31:0]             data_start;
      logic [CBYTES_WIDTH-1:0] cluster_bytes;
      logic                    layout_error;
   } layout_type;

endpackage

### rtl/fat32_layout_and_cluster_map.sv
// Top level: configuration registers, layout sequencer, divider chain and cluster mapper.
//
// Usage: write the volume size in sectors (address 0) and the cluster size in sectors
// (address 4) over the csr_ port; a cluster size of 0 counts as 1. Each write starts a
// layout pass: three divisions (fat pass one, fat pass two, cluster count) run in turn
// through a 32-cell divider row, so req_tready stays low after reset or after any
// write until the last division is done. Once the layout settles, the req_ channel
// takes one cluster value per cycle and the rsp_ channel returns one transaction per
// input through the product and output registers: the first sector in tdata together
// with fat size, cluster count, data start and cluster bytes, and the end-of-chain,
// valid-cluster and layout-error flags in tuser.
// The sustained rate is one transaction per cycle, set by the two-stage multiply/add
// pipeline. When the receiver stalls, the output register holds its transaction and the
// first stage can still take one more; beyond that req_tready drops.
// Reset clears both registers to their defaults (0 sectors, 1 sector per cluster),
// empties the pipeline and starts a layout pass.
module fat32_layout_and_cluster_map (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] cluster
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] first_sector, [57:32] fat_sectors, [89:58] cluster_count,
   // [121:90] data_start, [138:122] cluster_bytes, [143:139] zero
   output logic [143:0] rsp_tdata,
   // [0] end_of_chain, [1] valid_cluster, [2] layout_error
   output logic [2:0]   rsp_tuser
);
   import f32l_pkg::*;

   localparam logic REG_TOTAL = 1'b0;
   localparam logic REG_SPC   = 1'b1;

   typedef enum logic [3:0] {
      ST_DIV1  = 4'b0001,
      ST_DIV2  = 4'b0010,
      ST_DIV3  = 4'b0100,
      ST_READY = 4'b1000
   } seq_state_type;

   seq_state_type            state_ff, state_in;
   logic                     issued_ff, issued_in;
   logic [31:0]              tot_ff;
   logic [7:0]               spc_ff;
   logic [NEED_WIDTH-1:0]    need_ff, need_in;
   logic                     err_ff, err_in;
   logic [FAT_WIDTH-1:0]     fat_ff, fat_in;
   logic [31:0]              count_ff, count_in;
   logic                     cfg_write;
   logic [7:0]               eff_spc;
   logic [NEED_WIDTH-1:0]    dstart_w;
   logic [31:0]              sub_b;
   logic [31:0]              dividend;
   logic                     start;
   logic                     div_done;
   logic [31:0]              quotient;
   logic [32:0]              rounded;
   logic [FAT_WIDTH-1:0]     fat_q;
   layout_type               layout;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_TOTAL: csr_prdata = tot_ff;
         REG_SPC:   csr_prdata = {24'd0, spc_ff};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff <= '0;
         spc_ff <= 8'd1;
      end else if (cfg_write) begin
         case (csr_paddr[2])
            REG_TOTAL: tot_ff <= csr_pwdata;
            REG_SPC:   spc_ff <= csr_pwdata[7:0];
            default:   tot_ff <= tot_ff;
         endcase
      end
   end

   assign eff_spc  = (spc_ff == 8'd0) ? 8'd1 : spc_ff;
   assign dstart_w = RSVD_SECTORS[NEED_WIDTH-1:0] + {fat_ff, 1'b0};

   // Subtrahend of the saturating dividend for the current division.
   always_comb begin
      case (state_ff)
         ST_DIV1: sub_b = RSVD_SECTORS;
         ST_DIV2: sub_b = {5'd0, need_ff};
         ST_DIV3: sub_b = {5'd0, dstart_w};
         default: sub_b = RSVD_SECTORS;
      endcase
      dividend = (tot_ff > sub_b) ? (tot_ff - sub_b) : 32'd0;
   end

   assign start   = (state_ff != ST_READY) && !issued_ff;
   assign rounded = {1'b0, quotient} + FAT_ROUND;
   assign fat_q   = rounded[32:7];

   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      need_in   = need_ff;
      err_in    = err_ff;
      fat_in    = fat_ff;
      count_in  = count_ff;
      if (start) begin
         issued_in = 1'b1;
         if (state_ff == ST_DIV2) begin
            err_in = tot_ff < {5'd0, need_ff};
         end
      end
      if (div_done && issued_ff) begin
         issued_in = 1'b0;
         case (state_ff)
            ST_DIV1: begin
               need_in  = RSVD_SECTORS[NEED_WIDTH-1:0] + {fat_q, 1'b0};
               state_in = ST_DIV2;
            end
            ST_DIV2: begin
               fat_in   = fat_q;
               state_in = ST_DIV3;
            end
            ST_DIV3: begin
               count_in = quotient;
               state_in = ST_READY;
            end
            default: state_in = ST_READY;
         endcase
      end
      if (cfg_write) begin
         state_in  = ST_DIV1;
         issued_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_DIV1;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff  <= need_in;
      err_ff   <= err_in;
      fat_ff   <= fat_in;
      count_ff <= count_in;
   end

   f32l_div_chain u_div (
      .clock    (clock),
      .clear    (reset || cfg_write),
      .start    (start),
      .dividend (dividend),
      .divisor  (eff_spc),
      .done     (div_done),
      .quotient (quotient)
   );

   assign layout = '{
      fat_sectors:   fat_ff,
      cluster_count: count_ff,
      data_start:    {5'd0, dstart_w},
      cluster_bytes: {eff_spc, 9'd0},
      layout_error:  err_ff
   };

   f32l_mapper u_mapper (
      .clock      (clock),
      .reset      (reset),
      .layout_ok  (state_ff == ST_READY),
      .layout     (layout),
      .spc        (eff_spc),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### rtl/f32l_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands off to the next cell.
module f32l_div_cell (
   input  logic                    clock,
   input  logic                    clear,
   input  f32l_pkg::div_stage_type stage_in,
   output f32l_pkg::div_stage_type stage_out
);
   import f32l_pkg::*;

   logic [SPC_WIDTH:0]   trial;
   logic [SPC_WIDTH:0]   diff;
   logic                 fits;
   div_stage_type        stage_in_w;
   logic                 valid_ff;
   logic [DIV_WIDTH-1:0] word_ff;
   logic [SPC_WIDTH-1:0] rem_ff;
   logic [SPC_WIDTH-1:0] divisor_ff;

   always_comb begin
      trial = {stage_in.rem, stage_in.word[DIV_WIDTH-1]};
      diff  = trial - {1'b0, stage_in.divisor};
      fits  = trial >= {1'b0, stage_in.divisor};
      stage_in_w.valid   = stage_in.valid;
      stage_in_w.word    = {stage_in.word[DIV_WIDTH-2:0], fits};
      stage_in_w.rem     = fits ? diff[SPC_WIDTH-1:0] : trial[SPC_WIDTH-1:0];
      stage_in_w.divisor = stage_in.divisor;
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in_w.valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= stage_in_w.word;
      rem_ff     <= stage_in_w.rem;
      divisor_ff <= stage_in_w.divisor;
   end

   assign stage_out = '{valid: valid_ff, word: word_ff, rem: rem_ff, divisor: divisor_ff};

endmodule

### rtl/f32l_div_chain.sv
// Row of division cells: a 32-bit dividend by an 8-bit divisor, one bit per cell.
module f32l_div_chain (
   input  logic                    clock,
   input  logic                    clear,
   input  logic                    start,
   input  logic [31:0]             dividend,
   input  logic [7:0]              divisor,
   output logic                    done,
   output logic [31:0]             quotient
);
   import f32l_pkg::*;

   div_stage_type link [DIV_WIDTH+1];

   assign link[0] = '{valid: start, word: dividend, rem: '0, divisor: divisor};

   for (genvar i = 0; i < DIV_WIDTH; i++) begin : g_cell
      f32l_div_cell u_cell (
         .clock     (clock),
         .clear     (clear),
         .stage_in  (link[i]),
         .stage_out (link[i+1])
      );
   end

   assign done     = link[DIV_WIDTH].valid;
   assign quotient = link[DIV_WIDTH].word;

endmodule

### rtl/f32l_mapper.sv
// Two-stage cluster-to-sector pipeline with per-stage flow control.
module f32l_mapper (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 layout_ok,
   input  f32l_pkg::layout_type layout,
   input  logic [7:0]           spc,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [143:0]         rsp_tdata,
   output logic [2:0]           rsp_tuser
);
   import f32l_pkg::*;

   logic        out_en;
   logic        s1_en;
   logic [31:0] product;
   logic        s1_valid_ff;
   logic [31:0] s1_prod_ff;
   logic        s1_eoc_ff;
   logic        s1_vc_ff;
   logic        rsp_valid_ff;
   logic [31:0] first_ff;
   logic [31:0] first_in;
   logic        eoc_ff;
   logic        vc_ff;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || out_en;
   assign req_tready = layout_ok && s1_en;
   assign product    = (req_tdata - CLUSTER_MIN) * {24'd0, spc};
   assign first_in   = layout.data_start + s1_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_tvalid && req_tready;
         end
         if (out_en) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_ff <= product;
         s1_eoc_ff  <= req_tdata >= EOC_MIN;
         s1_vc_ff   <= (req_tdata >= CLUSTER_MIN) && (req_tdata <= CLUSTER_MAX);
      end
      if (out_en) begin
         first_ff <= first_in;
         eoc_ff   <= s1_eoc_ff;
         vc_ff    <= s1_vc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, layout.cluster_bytes, layout.data_start, layout.cluster_count,
                        layout.fat_sectors, first_ff};
   assign rsp_tuser  = {layout.layout_error, vc_ff, eoc_ff};

endmodule
